// ===== sv/mst_pkg.sv =====
`timescale 1ns / 1ps

package mst_pkg;

  localparam int CMD_W    = 3;
  localparam int ID_W     = 6;
  localparam int PERIOD_W = 16;
  localparam int TICK_W   = 16;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int QDEPTH   = 2;

  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_KILL    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESTART = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REFRESH = 3'd4;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd5;

  localparam logic [KIND_W-1:0] EV_FIRE  = 2'd0;
  localparam logic [KIND_W-1:0] EV_DONE  = 2'd1;
  localparam logic [KIND_W-1:0] EV_BADID = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TPS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAST = 1'd1;

  localparam logic [TICK_W-1:0] TPS_RESET  = 16'd1000;
  localparam logic [TICK_W-1:0] FAST_RESET = 16'd100;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [ID_W-1:0]     slot_id;
    logic [PERIOD_W-1:0] period_seconds;
  } cmd_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] event_kind;
    logic [ID_W-1:0]   event_slot;
    logic              slot_armed;
    logic              last_result;
  } result_item_t;

  typedef struct packed {
    logic [TICK_W-1:0] tps;
    logic [TICK_W-1:0] fast;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_REFRESH,
    OP_SET,
    OP_KILL,
    OP_RESTART,
    OP_QUERY,
    OP_NOP,
    OP_BADID
  } job_op_e;

  typedef struct packed {
    job_op_e             op;
    logic [ID_W-1:0]     slot;
    logic [PERIOD_W-1:0] period;
  } job_t;

  typedef struct packed {
    logic                armed;
    logic [PERIOD_W-1:0] period;
    logic [TICK_W-1:0]   sub;
    logic [TICK_W-1:0]   sec;
  } slot_entry_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EXEC,
    B_DONE
  } back_state_e;

endpackage

// ===== sv/multi_slot_periodic_timer.sv =====
`timescale 1ns / 1ps

// channel   | handshake           | payload
// ----------+---------------------+----------------------------------------
// command   | start, busy         | item   (cmd, slot_id, period_seconds)
// result    | result_valid        | result (event_kind, event_slot,
//           |                     |         slot_armed, last_result)
// config    | cfg_we              | cfg_index, cfg_data
//
// Tick and refresh pop the queue, then walk every slot through the slot RAM
// (read one slot ahead, write back the current), then give the done result.
// Other commands pop the queue, then execute and give their result.
// A 2-entry command queue sits in front; busy is high only while it is full.
// Reset is synchronous; slots read as zero at once via per-slot valid bits.
// Results appear for one cycle on result_valid; the receiver cannot stall.

module multi_slot_periodic_timer #(
  parameter int NUM_SLOTS = 16,
  parameter int FAST_SLOT = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  mst_pkg::cmd_item_t                  item,
  input  logic                                cfg_we,
  input  logic [mst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mst_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                result_valid,
  output mst_pkg::result_item_t               result
);

  import mst_pkg::*;

  cfg_t cfg;
  logic q_valid;
  job_t q_item;
  logic q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tps  <= TPS_RESET;
      cfg.fast <= FAST_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TPS:  cfg.tps  <= cfg_data;
        REG_FAST: cfg.fast <= cfg_data;
      endcase
    end
  end

  mst_front #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .item    (item),
    .busy    (busy),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  mst_back #(
    .NUM_SLOTS (NUM_SLOTS),
    .FAST_SLOT (FAST_SLOT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ===== sv/mst_ram.sv =====
`timescale 1ns / 1ps

module mst_ram #(
  parameter int WIDTH = 49,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/mst_front.sv =====
`timescale 1ns / 1ps

module mst_front #(
  parameter int NUM_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  mst_pkg::cmd_item_t item,
  output logic               busy,
  output logic               q_valid,
  output mst_pkg::job_t      q_item,
  input  logic               q_pop
);

  import mst_pkg::*;

  localparam int QAW = QDEPTH > 1 ? $clog2(QDEPTH) : 1;

  job_t           q_mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           push;
  logic           bad_id;
  job_t           job;

  // classify the incoming transaction
  always_comb begin
    bad_id     = item.slot_id >= ID_W'(NUM_SLOTS);
    job.slot   = item.slot_id;
    job.period = item.period_seconds;
    unique case (item.cmd)
      CMD_TICK:    job.op = OP_TICK;
      CMD_REFRESH: job.op = OP_REFRESH;
      CMD_SET:     job.op = bad_id ? OP_BADID : OP_SET;
      CMD_KILL:    job.op = bad_id ? OP_BADID : OP_KILL;
      CMD_RESTART: job.op = bad_id ? OP_BADID : OP_RESTART;
      CMD_QUERY:   job.op = bad_id ? OP_BADID : OP_QUERY;
      default:     job.op = OP_NOP;
    endcase
  end

  assign busy    = count == (QAW+1)'(QDEPTH);
  assign push    = start && !busy;
  assign q_valid = count != '0;
  assign q_item  = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= job;
    end
  end

endmodule

// ===== sv/mst_back.sv =====
`timescale 1ns / 1ps

module mst_back #(
  parameter int NUM_SLOTS = 16,
  parameter int FAST_SLOT = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mst_pkg::cfg_t         cfg,
  input  logic                  q_valid,
  input  mst_pkg::job_t         q_item,
  output logic                  q_pop,
  output logic                  result_valid,
  output mst_pkg::result_item_t result
);

  import mst_pkg::*;

  localparam int SW = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
  localparam bit HAS_FAST = FAST_SLOT < NUM_SLOTS;
  localparam logic [SW-1:0] FAST_IDX = HAS_FAST ? SW'(FAST_SLOT) : '0;
  localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);
  localparam int EW = $bits(slot_entry_t);

  back_state_e          state, state_next;
  job_t                 job;
  logic [SW-1:0]        idx;
  logic [NUM_SLOTS-1:0] vld;
  logic                 rd_vld;
  logic [SW-1:0]        rd_addr;
  logic [SW-1:0]        head_addr;
  logic [EW-1:0]        rdata;
  slot_entry_t          ent;
  logic                 wr_en;
  slot_entry_t          wr_data;
  logic                 ev_valid;
  result_item_t         ev;
  logic                 is_walk;
  logic                 walk_end;

  logic [TICK_W-1:0]    tps_eff;
  logic                 wrap;
  logic [TICK_W-1:0]    sub_n;
  logic [TICK_W-1:0]    sec_n;
  logic [2*TICK_W-1:0]  total;
  logic                 fire;
  slot_entry_t          tick_ent;

  mst_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // never-written entries read as zero
  assign ent      = rd_vld ? slot_entry_t'(rdata) : '0;
  assign is_walk  = job.op == OP_TICK || job.op == OP_REFRESH;
  assign walk_end = idx == LAST_IDX;

  assign head_addr = (q_item.op == OP_SET || q_item.op == OP_KILL ||
                      q_item.op == OP_RESTART || q_item.op == OP_QUERY) ?
                     q_item.slot[SW-1:0] : '0;

  // per-slot tick update
  always_comb begin
    tps_eff  = (cfg.tps == '0) ? TICK_W'(1) : cfg.tps;
    wrap     = ({1'b0, ent.sub} + (TICK_W+1)'(1)) >= {1'b0, tps_eff};
    sub_n    = wrap ? '0 : ent.sub + 1'b1;
    sec_n    = (wrap && ent.sec != '1) ? ent.sec + 1'b1 : ent.sec;
    total    = {{TICK_W{1'b0}}, sec_n} * {{TICK_W{1'b0}}, tps_eff}
             + {{TICK_W{1'b0}}, sub_n};
    if (HAS_FAST && idx == FAST_IDX) begin
      fire = total > {{TICK_W{1'b0}}, cfg.fast};
    end else begin
      fire = sec_n >= ent.period;
    end
    tick_ent     = ent;
    tick_ent.sub = fire ? '0 : sub_n;
    tick_ent.sec = fire ? '0 : sec_n;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          state_next = B_EXEC;
        end
      end
      B_EXEC: begin
        if (!is_walk) begin
          state_next = B_IDLE;
        end else if (walk_end) begin
          state_next = B_DONE;
        end
      end
      B_DONE:  state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_data  = ent;
    ev_valid = 1'b0;
    ev       = '0;
    unique case (state)
      B_IDLE: begin
        q_pop   = q_valid;
        rd_addr = head_addr;
      end
      B_EXEC: begin
        if (is_walk && !walk_end) begin
          rd_addr = idx + 1'b1;
        end
        unique case (job.op)
          OP_TICK: begin
            if (ent.period != '0) begin
              wr_en   = 1'b1;
              wr_data = tick_ent;
              if (fire && ent.armed) begin
                ev_valid      = 1'b1;
                ev.event_kind = EV_FIRE;
                ev.event_slot = ID_W'(idx);
              end
            end
          end
          OP_REFRESH: begin
            if (ent.period != '0) begin
              wr_en       = 1'b1;
              wr_data.sub = '0;
              wr_data.sec = '0;
            end
          end
          OP_SET: begin
            wr_en          = 1'b1;
            wr_data.armed  = 1'b1;
            wr_data.period = job.period;
            wr_data.sub    = '0;
            wr_data.sec    = '0;
            ev_valid       = 1'b1;
            ev             = '{EV_DONE, job.slot, 1'b0, 1'b1};
          end
          OP_KILL: begin
            wr_en          = 1'b1;
            wr_data.armed  = 1'b0;
            wr_data.period = '0;
            ev_valid       = 1'b1;
            ev             = '{EV_DONE, job.slot, 1'b0, 1'b1};
          end
          OP_RESTART: begin
            wr_en       = 1'b1;
            wr_data.sub = '0;
            wr_data.sec = '0;
            ev_valid    = 1'b1;
            ev          = '{EV_DONE, job.slot, 1'b0, 1'b1};
          end
          OP_QUERY: begin
            ev_valid = 1'b1;
            ev       = '{EV_DONE, job.slot, ent.armed, 1'b1};
          end
          OP_NOP: begin
            ev_valid = 1'b1;
            ev       = '{EV_DONE, '0, 1'b0, 1'b1};
          end
          OP_BADID: begin
            ev_valid = 1'b1;
            ev       = '{EV_BADID, job.slot, 1'b0, 1'b1};
          end
          default: ;
        endcase
      end
      B_DONE: begin
        ev_valid = 1'b1;
        ev       = '{EV_DONE, '0, 1'b0, 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      result_valid <= 1'b0;
      vld          <= '0;
    end else begin
      state        <= state_next;
      result_valid <= ev_valid;
      if (wr_en) begin
        vld[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= ev;
    rd_vld <= vld[rd_addr];
    if (q_pop) begin
      job <= q_item;
      idx <= rd_addr;
    end else if (state == B_EXEC && is_walk && !walk_end) begin
      idx <= idx + 1'b1;
    end
  end

endmodule

// ===== sv/mst_checker.sv =====
`timescale 1ns / 1ps

module mst_checker #(
  parameter int NUM_SLOTS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  busy,
  input logic                  result_valid,
  input mst_pkg::result_item_t result
);

  import mst_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid && !busy)
    else $error("result or busy right after reset");

  a_fire_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.event_kind == EV_FIRE |->
      !result.last_result && result.event_slot < ID_W'(NUM_SLOTS))
    else $error("bad fire transaction");

  a_badid_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.event_kind == EV_BADID |->
      result.last_result && result.event_slot >= ID_W'(NUM_SLOTS))
    else $error("bad invalid-id transaction");

  a_armed_only_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.slot_armed |->
      result.event_kind == EV_DONE && result.last_result)
    else $error("armed flag outside query answer");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.event_kind <= EV_BADID)
    else $error("illegal event kind");

endmodule

bind multi_slot_periodic_timer mst_checker #(
  .NUM_SLOTS (NUM_SLOTS)
) u_mst_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);
